// ===== src/csic_pkg.sv =====
package csic_pkg;

  localparam int TIME_BITS     = 32;
  localparam int POSITION_BITS = 32;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_ROUTE_ONE  = 3'd1;
  localparam logic [2:0] CMD_ROUTE_BOTH = 3'd2;
  localparam logic [2:0] CMD_STOP       = 3'd3;
  localparam logic [2:0] CMD_REVERSE    = 3'd4;

  localparam logic [1:0] TGT_KEEP   = 2'd0;
  localparam logic [1:0] TGT_KICK   = 2'd1;
  localparam logic [1:0] TGT_LIFT   = 2'd2;
  localparam logic [1:0] TGT_UNUSED = 2'd3;

  localparam logic COLOR_RED  = 1'b0;
  localparam logic COLOR_BLUE = 1'b1;

  localparam logic [2:0] REG_KICK_INTAKE = 3'd0;
  localparam logic [2:0] REG_KICK_HOLD   = 3'd1;
  localparam logic [2:0] REG_LIFT_REV    = 3'd2;
  localparam logic [2:0] REG_LIFT_TRAVEL = 3'd3;
  localparam logic [2:0] REG_PROX_THRESH = 3'd4;
  localparam logic [2:0] REG_RED_WINDOW  = 3'd5;

  localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CODE_REVERSE  = 3'd1;
  localparam logic [2:0] MODE_CODE_FILTER   = 3'd2;
  localparam logic [2:0] MODE_CODE_TO_KICK  = 3'd3;
  localparam logic [2:0] MODE_CODE_KICKING  = 3'd4;
  localparam logic [2:0] MODE_CODE_TO_LIFT  = 3'd5;
  localparam logic [2:0] MODE_CODE_LIFT_REV = 3'd6;

  localparam logic signed [7:0] DRIVE_FWD  = 8'sd127;
  localparam logic signed [7:0] DRIVE_REV  = -8'sd127;
  localparam logic signed [7:0] DRIVE_STOP = 8'sd0;

  localparam logic [8:0] HUE_FULL = 9'd360;
  localparam logic [8:0] HUE_HALF = 9'd180;

  typedef enum logic [6:0] {
    M_IDLE     = 7'b0000001,
    M_REVERSE  = 7'b0000010,
    M_FILTER   = 7'b0000100,
    M_TO_KICK  = 7'b0001000,
    M_KICKING  = 7'b0010000,
    M_TO_LIFT  = 7'b0100000,
    M_LIFT_REV = 7'b1000000
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [1:0]                red_route;
    logic [1:0]                blue_route;
    logic                      held_color;
    logic [TIME_BITS-1:0]      entry_time;
    logic [POSITION_BITS-1:0]  entry_pos;
    logic signed [7:0]         drive;
    logic                      kicker;
  } csic_state_t;

  typedef struct packed {
    logic [2:0]                cmd;
    logic [TIME_BITS-1:0]      now;
    logic [POSITION_BITS-1:0]  pos;
    logic [7:0]                prox;
    logic [8:0]                hue;
    logic                      color;
    logic [1:0]                target;
  } csic_item_t;

  typedef struct packed {
    logic [15:0] kick_intake;
    logic [15:0] kick_hold;
    logic [15:0] lift_reverse;
    logic [19:0] lift_travel;
    logic [7:0]  prox_thresh;
    logic [7:0]  red_window;
  } csic_cfg_t;

endpackage

// ===== src/csic_step.sv =====
module csic_step
  import csic_pkg::*;
(
  input  csic_state_t state_i,
  input  csic_item_t  item_i,
  input  csic_cfg_t   cfg_i,
  output csic_state_t state_o
);

  function automatic csic_state_t enter_mode(csic_state_t s, mode_t nxt, csic_item_t it);
    csic_state_t r;
    r = s;
    if (nxt != s.mode) begin
      if (s.mode == M_KICKING) begin
        r.kicker = 1'b0;
      end
      if (nxt == M_TO_KICK || nxt == M_KICKING || nxt == M_TO_LIFT || nxt == M_LIFT_REV) begin
        r.entry_time = it.now;
        r.entry_pos  = it.pos;
      end
      if (nxt == M_KICKING) begin
        r.kicker = 1'b1;
      end
      r.mode = nxt;
    end
    return r;
  endfunction

  function automatic logic time_over(csic_state_t s, csic_item_t it, logic [15:0] limit);
    logic [TIME_BITS-1:0] elapsed;
    elapsed = it.now - s.entry_time;
    return elapsed > TIME_BITS'(limit);
  endfunction

  function automatic logic travel_over(csic_state_t s, csic_item_t it, logic [19:0] limit);
    logic [POSITION_BITS-1:0] d;
    d = it.pos - s.entry_pos;
    return !d[POSITION_BITS-1] && (32'(d) > 32'(limit));
  endfunction

  function automatic csic_state_t evaluate(csic_state_t s, csic_item_t it, csic_cfg_t c);
    csic_state_t r;
    logic [8:0]  h;
    logic [8:0]  hue_gap;
    logic        color;
    logic [1:0]  dest;
    r = s;
    h = (it.hue >= HUE_FULL) ? it.hue - HUE_FULL : it.hue;
    hue_gap = (h <= HUE_HALF) ? h : HUE_FULL - h;
    color = (hue_gap < {1'b0, c.red_window}) ? COLOR_RED : COLOR_BLUE;
    dest = (color == COLOR_BLUE) ? s.blue_route : s.red_route;
    unique case (s.mode)
      M_IDLE: begin
        r.drive = DRIVE_STOP;
      end
      M_REVERSE: begin
        r.drive = DRIVE_REV;
      end
      M_FILTER: begin
        r.drive = DRIVE_FWD;
        if (it.prox >= c.prox_thresh) begin
          if (dest == TGT_KICK) begin
            r.held_color = color;
            r = enter_mode(r, M_TO_KICK, it);
          end else if (dest == TGT_LIFT) begin
            r.held_color = color;
            r = enter_mode(r, M_TO_LIFT, it);
          end
        end
      end
      M_TO_KICK: begin
        r.drive = DRIVE_FWD;
        if (time_over(s, it, c.kick_intake)) begin
          r = enter_mode(r, M_KICKING, it);
        end
      end
      M_KICKING: begin
        r.drive = DRIVE_FWD;
        if (time_over(s, it, c.kick_hold)) begin
          r = enter_mode(r, M_FILTER, it);
        end
      end
      M_TO_LIFT: begin
        r.drive = DRIVE_FWD;
        if (travel_over(s, it, c.lift_travel)) begin
          r = enter_mode(r, M_LIFT_REV, it);
        end
      end
      M_LIFT_REV: begin
        r.drive = DRIVE_REV;
        if (time_over(s, it, c.lift_reverse)) begin
          r = enter_mode(r, M_FILTER, it);
        end
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  function automatic csic_state_t route(csic_state_t s, logic color, logic [1:0] target,
                                        csic_item_t it);
    csic_state_t r;
    logic [1:0]  tgt;
    r = s;
    tgt = (target == TGT_UNUSED) ? TGT_KEEP : target;
    if (s.mode == M_IDLE || s.mode == M_REVERSE) begin
      r.red_route  = TGT_KEEP;
      r.blue_route = TGT_KEEP;
      if (color == COLOR_BLUE) begin
        r.blue_route = tgt;
      end else begin
        r.red_route = tgt;
      end
      r = enter_mode(r, M_FILTER, it);
    end else begin
      if (color == COLOR_BLUE) begin
        r.blue_route = tgt;
      end else begin
        r.red_route = tgt;
      end
      if (color == s.held_color) begin
        if (s.mode == M_TO_KICK) begin
          if (tgt == TGT_LIFT) begin
            r = enter_mode(r, M_TO_LIFT, it);
          end else if (tgt == TGT_KEEP) begin
            r = enter_mode(r, M_FILTER, it);
          end
        end else if (s.mode == M_TO_LIFT) begin
          if (tgt == TGT_KICK) begin
            r = enter_mode(r, M_TO_KICK, it);
          end else if (tgt == TGT_KEEP) begin
            r = enter_mode(r, M_FILTER, it);
          end
        end
      end
    end
    return r;
  endfunction

  csic_state_t eval1;
  csic_state_t eval2;
  csic_state_t eval3;
  csic_state_t tick_st;
  csic_state_t both_st;
  csic_state_t halt_st;

  // A mode change on a tick runs the new mode again, at most three passes.
  always_comb begin
    eval1 = evaluate(state_i, item_i, cfg_i);
    eval2 = evaluate(eval1, item_i, cfg_i);
    eval3 = evaluate(eval2, item_i, cfg_i);
    if (eval1.mode == state_i.mode) begin
      tick_st = eval1;
    end else if (eval2.mode == eval1.mode) begin
      tick_st = eval2;
    end else begin
      tick_st = eval3;
    end
    both_st = route(route(state_i, COLOR_RED, item_i.target, item_i),
                    COLOR_BLUE, item_i.target, item_i);
    halt_st = enter_mode(state_i, (item_i.cmd == CMD_STOP) ? M_IDLE : M_REVERSE, item_i);
    halt_st.red_route  = TGT_KEEP;
    halt_st.blue_route = TGT_KEEP;
  end

  always_comb begin
    unique case (item_i.cmd)
      CMD_TICK:       state_o = tick_st;
      CMD_ROUTE_ONE:  state_o = route(state_i, item_i.color, item_i.target, item_i);
      CMD_ROUTE_BOTH: state_o = both_st;
      CMD_STOP:       state_o = halt_st;
      CMD_REVERSE:    state_o = halt_st;
      default:        state_o = state_i;
    endcase
  end

endmodule

// ===== src/color_sort_intake_controller.sv =====
// An accepted transfer is held in the input register, then its result in the output register.
// Throughput: one item per cycle unless the output stalls; the state update for an item
// is a single registered pass. An input register and an output register decouple the
// channels, so a stalled result still lets one further item be taken.
// Reset (rst_n low, synchronous): idle mode, all routes keep, kicker retracted, drive zero,
// registers at their defaults, both pipeline registers empty.
module color_sort_intake_controller
  import csic_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [31:0]        in_now_ms,
  input  logic signed [31:0] in_motor_position,
  input  logic [7:0]         in_proximity,
  input  logic [8:0]         in_hue,
  input  logic               in_route_color,
  input  logic [1:0]         in_route_target,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [7:0]  out_motor_drive,
  output logic               out_kicker_on,
  output logic               out_led_on,
  output logic [2:0]         out_mode_now,
  output logic [1:0]         out_red_target,
  output logic [1:0]         out_blue_target,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  csic_cfg_t   cfg_r;
  csic_item_t  item_r;
  logic        item_vld_r;
  csic_state_t state_r;
  csic_state_t state_nxt;
  logic        advance;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [2:0]  mode_code;

  logic              out_valid_r;
  logic signed [7:0] out_drive_r;
  logic              out_kicker_r;
  logic              out_led_r;
  logic [2:0]        out_mode_r;
  logic [1:0]        out_red_r;
  logic [1:0]        out_blue_r;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kick_intake  <= 16'd0;
      cfg_r.kick_hold    <= 16'd0;
      cfg_r.lift_reverse <= 16'd0;
      cfg_r.lift_travel  <= 20'd0;
      cfg_r.prox_thresh  <= 8'd200;
      cfg_r.red_window   <= 8'd60;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KICK_INTAKE: cfg_r.kick_intake  <= cfg_pwdata[15:0];
        REG_KICK_HOLD:   cfg_r.kick_hold    <= cfg_pwdata[15:0];
        REG_LIFT_REV:    cfg_r.lift_reverse <= cfg_pwdata[15:0];
        REG_LIFT_TRAVEL: cfg_r.lift_travel  <= cfg_pwdata[19:0];
        REG_PROX_THRESH: cfg_r.prox_thresh  <= cfg_pwdata[7:0];
        REG_RED_WINDOW:  cfg_r.red_window   <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KICK_INTAKE: cfg_prdata = {16'd0, cfg_r.kick_intake};
      REG_KICK_HOLD:   cfg_prdata = {16'd0, cfg_r.kick_hold};
      REG_LIFT_REV:    cfg_prdata = {16'd0, cfg_r.lift_reverse};
      REG_LIFT_TRAVEL: cfg_prdata = {12'd0, cfg_r.lift_travel};
      REG_PROX_THRESH: cfg_prdata = {24'd0, cfg_r.prox_thresh};
      REG_RED_WINDOW:  cfg_prdata = {24'd0, cfg_r.red_window};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign advance   = item_vld_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_vld_r || advance;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.cmd    <= in_command;
      item_r.now    <= in_now_ms[TIME_BITS-1:0];
      item_r.pos    <= in_motor_position[POSITION_BITS-1:0];
      item_r.prox   <= in_proximity;
      item_r.hue    <= in_hue;
      item_r.color  <= in_route_color;
      item_r.target <= in_route_target;
    end
  end

  csic_step u_step (
    .state_i (state_r),
    .item_i  (item_r),
    .cfg_i   (cfg_r),
    .state_o (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= M_IDLE;
      state_r.red_route  <= TGT_KEEP;
      state_r.blue_route <= TGT_KEEP;
      state_r.held_color <= COLOR_RED;
      state_r.entry_time <= '0;
      state_r.entry_pos  <= '0;
      state_r.drive      <= DRIVE_STOP;
      state_r.kicker     <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    unique case (state_nxt.mode)
      M_IDLE:     mode_code = MODE_CODE_IDLE;
      M_REVERSE:  mode_code = MODE_CODE_REVERSE;
      M_FILTER:   mode_code = MODE_CODE_FILTER;
      M_TO_KICK:  mode_code = MODE_CODE_TO_KICK;
      M_KICKING:  mode_code = MODE_CODE_KICKING;
      M_TO_LIFT:  mode_code = MODE_CODE_TO_LIFT;
      M_LIFT_REV: mode_code = MODE_CODE_LIFT_REV;
      default:    mode_code = MODE_CODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_r  <= state_nxt.drive;
      out_kicker_r <= state_nxt.kicker;
      out_led_r    <= !(state_nxt.mode == M_IDLE || state_nxt.mode == M_REVERSE);
      out_mode_r   <= mode_code;
      out_red_r    <= state_nxt.red_route;
      out_blue_r   <= state_nxt.blue_route;
    end
  end

  assign out_motor_drive = out_drive_r;
  assign out_kicker_on   = out_kicker_r;
  assign out_led_on      = out_led_r;
  assign out_mode_now    = out_mode_r;
  assign out_red_target  = out_red_r;
  assign out_blue_target = out_blue_r;

`ifndef SYNTHESIS
  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.mode))
    else $error("mode register is not one-hot");

  a_kicker_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.kicker == (state_r.mode == M_KICKING))
    else $error("kicker state disagrees with kicking mode");

  a_idle_routes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == M_IDLE || state_r.mode == M_REVERSE) |->
      (state_r.red_route == TGT_KEEP && state_r.blue_route == TGT_KEEP))
    else $error("routes set while idle or reversing");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (item_vld_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without a transfer");
`endif

endmodule
